### src/tlmc_pkg.sv
`timescale 1ns / 1ps
// Package for the touch-qualified light mode controller.
// Holds widths, reset values, mode and command codes and the color ROM.
// No dependencies.
package tlmc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int BASE_W     = SAMPLE_W + FRAC_W;
    localparam int DEV_W      = BASE_W + 1;
    localparam int STEP_SHIFT = 10;
    localparam int COLOR_W    = 8;
    localparam int CIDX_W     = 3;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    localparam logic [15:0] THRESHOLD_RST   = 16'd15;
    localparam logic [7:0]  COUNT_LIMIT_RST = 8'd10;
    localparam logic [7:0]  DEBOUNCE_RST    = 8'd60;

    localparam logic [7:0] SPEED_ON    = 8'd50;
    localparam logic [7:0] SPEED_OFF   = 8'd100;
    localparam logic [7:0] SPEED_CYCLE = 8'd255;
    localparam logic [7:0] WHITE_LEVEL = 8'd120;
    localparam logic [7:0] RUN_MAX     = 8'd255;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_WHITE = 2'd1,
        MODE_CYCLE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        LAMP_NONE = 2'd0,
        LAMP_ON   = 2'd1,
        LAMP_OFF  = 2'd2
    } t_white;

    typedef enum logic [1:0] {
        CFG_THRESHOLD   = 2'd0,
        CFG_COUNT_LIMIT = 2'd1,
        CFG_DEBOUNCE    = 2'd2
    } t_cfg_addr;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [1:0]          light_mode;
        logic                fade_valid;
        t_rgb                fade_color;
        logic [7:0]          fade_speed;
        logic [1:0]          white_action;
        logic [SAMPLE_W-1:0] touch_delta;
    } t_result;

    function automatic t_rgb f_color_rom(input logic [CIDX_W-1:0] idx);
        t_rgb c;
        case (idx)
            3'd0:    c = '{8'd255, 8'd0,   8'd0};
            3'd1:    c = '{8'd255, 8'd255, 8'd0};
            3'd2:    c = '{8'd0,   8'd255, 8'd0};
            3'd3:    c = '{8'd0,   8'd255, 8'd255};
            3'd4:    c = '{8'd0,   8'd0,   8'd255};
            3'd5:    c = '{8'd255, 8'd0,   8'd255};
            3'd6:    c = '{8'd255, 8'd255, 8'd255};
            default: c = '{8'd255, 8'd120, 8'd0};
        endcase
        return c;
    endfunction

endpackage

### src/tlmc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the light mode controller.
// Depends on tlmc_pkg for field widths.
interface tlmc_in_if import tlmc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                operation;
    logic [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output operation, output sample_value, input ready);
    modport sink   (input valid, input operation, input sample_value, output ready);
endinterface

interface tlmc_out_if import tlmc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          light_mode;
    logic                fade_valid;
    logic [COLOR_W-1:0]  fade_red;
    logic [COLOR_W-1:0]  fade_green;
    logic [COLOR_W-1:0]  fade_blue;
    logic [7:0]          fade_speed;
    logic [1:0]          white_action;
    logic [SAMPLE_W-1:0] touch_delta;

    modport source (
        output valid, output light_mode, output fade_valid, output fade_red,
        output fade_green, output fade_blue, output fade_speed,
        output white_action, output touch_delta, input ready
    );
    modport sink (
        input valid, input light_mode, input fade_valid, input fade_red,
        input fade_green, input fade_blue, input fade_speed,
        input white_action, input touch_delta, output ready
    );
endinterface

### src/touch_qualified_light_mode_controller_top.sv
`timescale 1ns / 1ps
// Touch-qualified light mode controller, top level.
// Latency: a result is valid in the cycle after its input transaction.
// Throughput: one transaction per cycle unless o_out stalls; output register frees as taken.
// Reset (i_rst_n low, synchronous): state and output valid clear, registers load 15, 10, 60.
// Depends on tlmc_pkg and tlmc_if.
module touch_qualified_light_mode_controller_top import tlmc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tlmc_in_if.sink           i_in,
    tlmc_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [15:0]         r_threshold;
    logic [7:0]          r_count_limit;
    logic [7:0]          r_debounce_ticks;

    logic [BASE_W-1:0]   r_baseline, n_baseline;
    logic                r_loaded, n_loaded;
    logic [7:0]          r_run, n_run;
    logic [7:0]          r_debounce, n_debounce;
    t_mode               r_mode, n_mode;
    logic [7:0]          r_phase, n_phase;
    logic [CIDX_W-1:0]   r_cidx, n_cidx;

    t_result             r_out, n_out;
    logic                r_out_valid;

    logic                w_accept;
    logic                w_cfg_wr;
    logic [BASE_W-1:0]   w_target;
    logic signed [DEV_W-1:0] w_dev;
    logic signed [DEV_W-1:0] w_step;
    logic [DEV_W-1:0]    w_abs;
    logic [SAMPLE_W-1:0] w_delta;
    logic [7:0]          w_run_inc;
    logic                w_fire;
    logic                w_take;
    logic                w_wrap;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold      <= THRESHOLD_RST;
            r_count_limit    <= COUNT_LIMIT_RST;
            r_debounce_ticks <= DEBOUNCE_RST;
        end else if (w_cfg_wr) begin
            unique case (t_cfg_addr'(paddr[3:2]))
                CFG_THRESHOLD:   r_threshold      <= pwdata[15:0];
                CFG_COUNT_LIMIT: r_count_limit    <= pwdata[7:0];
                CFG_DEBOUNCE:    r_debounce_ticks <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_cfg_addr'(paddr[3:2]))
            CFG_THRESHOLD:   prdata = {16'd0, r_threshold};
            CFG_COUNT_LIMIT: prdata = {24'd0, r_count_limit};
            CFG_DEBOUNCE:    prdata = {24'd0, r_debounce_ticks};
            default:         prdata = '0;
        endcase
    end

    // baseline filter, deviation kept to one extra sign bit
    assign w_target = {i_in.sample_value, {FRAC_W{1'b0}}};
    assign w_dev    = $signed({1'b0, w_target}) - $signed({1'b0, r_baseline});
    assign w_step   = w_dev[DEV_W-1]
                    ? ((w_dev + DEV_W'(33'sd1023)) >>> STEP_SHIFT)
                    : (w_dev >>> STEP_SHIFT);
    assign w_abs    = w_dev[DEV_W-1] ? DEV_W'(-w_dev) : DEV_W'(w_dev);
    assign w_delta  = r_loaded ? w_abs[BASE_W-1:FRAC_W] : '0;

    assign w_run_inc = (w_delta > r_threshold)
                     ? ((r_run == RUN_MAX) ? r_run : r_run + 8'd1) : 8'd0;
    assign w_fire    = (i_in.operation == OP_SAMPLE) && (w_run_inc > r_count_limit);
    assign w_take    = w_fire && (r_debounce == 8'd0);
    assign w_wrap    = (i_in.operation == OP_TICK) && (r_mode == MODE_CYCLE)
                     && (r_phase == 8'd255);

    // next state
    always_comb begin
        n_baseline = r_baseline;
        n_loaded   = r_loaded;
        n_run      = r_run;
        n_debounce = r_debounce;
        n_mode     = r_mode;
        n_phase    = r_phase;
        n_cidx     = r_cidx;
        if (i_in.operation == OP_TICK) begin
            if (r_debounce != 8'd0) begin
                n_debounce = r_debounce - 8'd1;
            end
            if (r_mode == MODE_CYCLE) begin
                n_phase = r_phase + 8'd1;
                if (w_wrap) begin
                    n_cidx = r_cidx + CIDX_W'(1);
                end
            end
        end else begin
            n_loaded   = 1'b1;
            n_baseline = r_loaded ? (r_baseline + w_step[BASE_W-1:0]) : w_target;
            n_run      = w_fire ? 8'd0 : w_run_inc;
            if (w_take) begin
                n_debounce = r_debounce_ticks;
                unique case (r_mode)
                    MODE_OFF:   n_mode = MODE_WHITE;
                    MODE_WHITE: n_mode = MODE_CYCLE;
                    MODE_CYCLE: n_mode = MODE_OFF;
                    default:    n_mode = r_mode;
                endcase
            end
        end
    end

    // result
    always_comb begin
        n_out              = '0;
        n_out.light_mode   = n_mode;
        if (i_in.operation == OP_TICK) begin
            if (w_wrap) begin
                n_out.fade_valid = 1'b1;
                n_out.fade_color = f_color_rom(r_cidx + CIDX_W'(1));
                n_out.fade_speed = SPEED_CYCLE;
            end
        end else begin
            n_out.touch_delta = w_delta;
            if (w_take) begin
                unique case (r_mode)
                    MODE_OFF: begin
                        n_out.fade_valid   = 1'b1;
                        n_out.fade_color   = '{WHITE_LEVEL, WHITE_LEVEL, 8'd0};
                        n_out.fade_speed   = SPEED_ON;
                        n_out.white_action = LAMP_ON;
                    end
                    MODE_WHITE: n_out.white_action = LAMP_OFF;
                    MODE_CYCLE: begin
                        n_out.fade_valid = 1'b1;
                        n_out.fade_speed = SPEED_OFF;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline  <= '0;
            r_loaded    <= 1'b0;
            r_run       <= '0;
            r_debounce  <= '0;
            r_mode      <= MODE_OFF;
            r_phase     <= '0;
            r_cidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_baseline <= n_baseline;
                r_loaded   <= n_loaded;
                r_run      <= n_run;
                r_debounce <= n_debounce;
                r_mode     <= n_mode;
                r_phase    <= n_phase;
                r_cidx     <= n_cidx;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.light_mode   = r_out.light_mode;
    assign o_out.fade_valid   = r_out.fade_valid;
    assign o_out.fade_red     = r_out.fade_color.red;
    assign o_out.fade_green   = r_out.fade_color.green;
    assign o_out.fade_blue    = r_out.fade_color.blue;
    assign o_out.fade_speed   = r_out.fade_speed;
    assign o_out.white_action = r_out.white_action;
    assign o_out.touch_delta  = r_out.touch_delta;

    a_mode_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != $past(r_mode)) |-> $past(w_accept))
        else $error("mode changed without a transaction");

    a_mode_change_loads_debounce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_take |=> (r_debounce == $past(r_debounce_ticks)))
        else $error("touch did not load debounce");

    a_lamp_on_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.white_action == LAMP_ON) |-> (r_out.light_mode == MODE_WHITE))
        else $error("white on issued outside white mode");

    a_fade_speed_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.fade_valid |->
        (r_out.fade_speed == SPEED_ON) || (r_out.fade_speed == SPEED_OFF)
        || (r_out.fade_speed == SPEED_CYCLE))
        else $error("fade issued with unexpected speed");

endmodule
